FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on clk_i / rst_ni of the enclosing module
`define ASSERT_DEF(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/ntlv_pkg.sv
// Types, constants and the container tag lookup of the nested TLV parser
`timescale 1ns / 1ps
`default_nettype none
package ntlv_pkg;

  localparam int MaxDepthDefault = 8;
  localparam int LengthBits      = 32;
  localparam int HdrBytes        = 6;
  localparam int MaxResults      = 7;
  localparam int CntW            = 3;
  localparam int NumTags         = 36;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  localparam logic RegRegionStart  = 1'b0;
  localparam logic RegRegionLength = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] record_offset;
    logic [15:0] tag_value;
    logic [31:0] body_size;
    logic [3:0]  nest_level;
    logic        is_container;
    logic        depth_overflow;
    logic [7:0]  payload_byte;
    logic        last_of_input;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0]                  count;
    out_item_t [MaxResults-1:0]       items;
  } burst_t;

  localparam logic [15:0] ContainerTags [NumTags] = '{
    16'hF401, 16'hF701, 16'hD430, 16'hD530, 16'hC832, 16'h7C15, 16'h8813, 16'h8913,
    16'h8A13, 16'h8B13, 16'h8C13, 16'h8D13, 16'h4C1D, 16'h6419, 16'hF901, 16'h7017,
    16'h7117, 16'hD007, 16'hC409, 16'h9411, 16'h9511, 16'h0F01, 16'h384A, 16'hB80B,
    16'h9713, 16'h2C4C, 16'hAC0D, 16'hAE0D, 16'hF601, 16'hF801, 16'h983A, 16'h993A,
    16'h8C3C, 16'h8D3C, 16'h9013, 16'h401F
  };

  function automatic logic is_container_tag(logic [15:0] tag);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumTags; i++) begin
      if (ContainerTags[i] == tag) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ntlv_result_queue.sv
// Result burst buffer: holds a byte's results and drains one per cycle unless stalled
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ntlv_result_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_en_i,
  input  wire ntlv_pkg::burst_t   load_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output ntlv_pkg::out_item_t     out_data_o,
  output logic                    in_stall_o
);

  localparam int N = ntlv_pkg::MaxResults;
  localparam int W = ntlv_pkg::CntW;

  ntlv_pkg::out_item_t items_q [N];
  logic [W-1:0] cnt_q, idx_q, left;

  assign left        = cnt_q - idx_q;
  assign out_valid_o = (idx_q != cnt_q);
  // next byte may enter once the last pending result leaves this cycle
  assign in_stall_o  = (left > W'(1)) || ((left == W'(1)) && out_stall_i);
  assign out_data_o  = (32'(idx_q) < N) ? items_q[idx_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_en_i) begin
      cnt_q <= load_i.count;
      idx_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      idx_q <= idx_q + W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      for (int i = 0; i < N; i++) items_q[i] <= load_i.items[i];
    end
  end

  `ASSERT_DEF(a_idx_le_cnt, idx_q <= cnt_q)
  `ASSERT_DEF(a_load_only_drained, load_en_i |-> (left <= W'(1)))
  `ASSERT_DEF(a_drain_step, out_valid_o && !out_stall_i && !load_en_i |=> idx_q == $past(idx_q) + W'(1))

endmodule
`default_nettype wire

FILE: rtl/core/nested_tlv_record_parser_core.sv
// Top level of the nested TLV record parser
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one region byte per
//   transfer; first_byte restarts parsing at region byte 0. Region start and length
//   are set over the APB port (0x0 region_start, 0x4 region_length) while idle.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries header results
//   and leaf payload bytes; last_of_input marks the last result of a byte.
// Latency: results of a byte appear on the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and the
//   receiver does not stall. A byte with more results (up to six: a replayed
//   header or a short tail) stalls the input while the result buffer drains them.
// Reset clears the parser state and both registers; no results are pending.
// When the receiver stalls, the current result holds and the input stalls while
//   any result is pending.
// All nesting levels that end on a byte close in that byte's cycle through
//   parallel end compares against the level stack.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nested_tlv_record_parser_core #(
  parameter int MAX_DEPTH = ntlv_pkg::MaxDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ntlv_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ntlv_pkg::out_item_t      out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int N     = ntlv_pkg::MaxResults;
  localparam int CW    = ntlv_pkg::CntW;

  // configuration
  logic [31:0] rstart_q, rlen_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ntlv_pkg::RegRegionLength) ? rlen_q : rstart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rstart_q <= '0;
      rlen_q   <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == ntlv_pkg::RegRegionStart) rstart_q <= pwdata;
      else rlen_q <= pwdata;
    end
  end

  // parser state
  logic [31:0]          pos_q, pos_d, br_q, br_d;
  logic [2:0]           hc_q, hc_d;
  logic [LVL_W-1:0]     cl_q, cl_d;
  logic                 body_q, body_d, halt_q, halt_d;
  logic [MAX_DEPTH-1:0] hasc_q, hasc_d, skip_q, skip_d;
  logic [7:0]           hbuf_q [5];
  logic [7:0]           hbuf_d [5];
  logic [31:0]          stack_q [MAX_DEPTH];
  logic                 stack_we;
  logic [IDX_W-1:0]     stack_widx;
  logic [31:0]          stack_wdata;

  // effective state after an optional restart
  logic                 first, in_accept, active;
  logic [31:0]          pos_s, br_s;
  logic [2:0]           hc_s;
  logic [LVL_W-1:0]     cl_s;
  logic                 body_s, halt_s;
  logic [MAX_DEPTH-1:0] hasc_s, skip_s;
  logic [7:0]           b;

  assign in_accept = in_valid_i && !in_stall_o;
  assign first  = in_data_i.first_byte;
  assign b      = in_data_i.data_byte;
  assign pos_s  = first ? '0 : pos_q;
  assign br_s   = first ? '0 : br_q;
  assign hc_s   = first ? '0 : hc_q;
  assign cl_s   = first ? '0 : cl_q;
  assign body_s = first ? 1'b0 : body_q;
  assign halt_s = first ? 1'b0 : halt_q;
  assign hasc_s = first ? '0 : hasc_q;
  assign skip_s = first ? '0 : skip_q;
  assign active = (pos_s < rlen_q) && !halt_s;

  // header evaluation
  logic [IDX_W-1:0] lvl_m1;
  logic [31:0]      pos_inc, size, end_sel, rem;
  logic [32:0]      p1;
  logic [15:0]      tag;
  logic             ok, isc, ovf, lvl_skip;
  logic [7:0]       sixb [6];

  assign lvl_m1   = IDX_W'(cl_s - LVL_W'(1));
  assign lvl_skip = (cl_s != '0) && skip_s[lvl_m1];
  assign pos_inc  = pos_s + 32'd1;
  assign size     = {b, hbuf_q[4], hbuf_q[3], hbuf_q[2]};
  assign tag      = {hbuf_q[0], hbuf_q[1]};
  assign end_sel  = (cl_s == '0) ? rlen_q : stack_q[lvl_m1];
  assign p1       = {1'b0, pos_s} + 33'd1;
  assign rem      = ({1'b0, end_sel} > p1) ? 32'({1'b0, end_sel} - p1) : '0;
  assign ok       = ((size >> ntlv_pkg::LengthBits) == '0) && (size <= rem);
  assign isc      = (size != '0) && ntlv_pkg::is_container_tag(tag);
  assign ovf      = isc && (32'(cl_s) >= MAX_DEPTH);

  always_comb begin
    for (int i = 0; i < 5; i++) sixb[i] = hbuf_q[i];
    sixb[5] = b;
  end

  logic [LVL_W-1:0] cl_d_mid;
  logic [2:0]       hc_mid;
  logic             pushed, emit_hdr, emit_six, emit_body, emit_close, closing;
  logic [IDX_W-1:0] close_k;
  logic [LVL_W-1:0] n_close;

  // level end compares, all in parallel
  logic [MAX_DEPTH-1:0] cmp, cmask;
  always_comb begin
    for (int j = 0; j < MAX_DEPTH; j++) begin
      cmp[j]   = stack_q[j] <= pos_inc;
      cmask[j] = (j < 32'(cl_d_mid));
    end
  end

  assign close_k = IDX_W'(cl_d_mid - LVL_W'(1));
  assign n_close = LVL_W'($countones(cmp & cmask));
  assign closing = in_accept && active && !pushed && (cl_d_mid != '0) && cmp[close_k];

  always_comb begin
    pos_d = pos_q; br_d = br_q; hc_mid = hc_q; cl_d_mid = cl_q; body_d = body_q;
    halt_d = halt_q; hasc_d = hasc_q; skip_d = skip_q;
    for (int i = 0; i < 5; i++) hbuf_d[i] = hbuf_q[i];
    stack_we = 1'b0; stack_widx = IDX_W'(cl_s); stack_wdata = pos_inc + size;
    pushed = 1'b0; emit_hdr = 1'b0; emit_six = 1'b0; emit_body = 1'b0;
    if (in_accept) begin
      pos_d = pos_s; br_d = br_s; hc_mid = hc_s; cl_d_mid = cl_s; body_d = body_s;
      halt_d = halt_s; hasc_d = hasc_s; skip_d = skip_s;
      if (active) begin
        pos_d = pos_inc;
        if (body_s) begin
          emit_body = 1'b1;
          br_d   = br_s - ((br_s != '0) ? 32'd1 : 32'd0);
          body_d = (br_d != '0);
        end else if (lvl_skip) begin
          // rest of the level is dropped
        end else if (hc_s != 3'(ntlv_pkg::HdrBytes - 1)) begin
          hbuf_d[hc_s] = b;
          hc_mid = hc_s + 3'd1;
        end else begin
          hc_mid = '0;
          if (ok) begin
            emit_hdr = 1'b1;
            if (cl_s != '0) hasc_d[lvl_m1] = 1'b1;
            if (isc && !ovf) begin
              stack_we = 1'b1;
              hasc_d[IDX_W'(cl_s)] = 1'b0;
              skip_d[IDX_W'(cl_s)] = 1'b0;
              cl_d_mid = cl_s + LVL_W'(1);
              pushed = 1'b1;
            end else if (size != '0) begin
              body_d = 1'b1;
              br_d   = size;
            end
          end else if (cl_s == '0) begin
            halt_d = 1'b1;
          end else if (!hasc_s[lvl_m1]) begin
            // bad first child: the container body turns into payload
            emit_six = 1'b1;
            cl_d_mid = cl_s - LVL_W'(1);
            if (rem != '0) begin
              body_d = 1'b1;
              br_d   = rem;
            end
          end else begin
            skip_d[lvl_m1] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    cl_d = cl_d_mid;
    hc_d = hc_mid;
    emit_close = 1'b0;
    if (closing) begin
      emit_close = !hasc_d[close_k] && !skip_d[close_k] && (hc_mid != '0);
      cl_d = cl_d_mid - n_close;
      hc_d = '0;
    end
  end

  logic body_fin;
  logic [31:0] br_fin;
  assign body_fin = closing ? 1'b0 : body_d;
  assign br_fin   = closing ? '0 : br_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; br_q <= '0; hc_q <= '0; cl_q <= '0;
      body_q <= 1'b0; halt_q <= 1'b0; hasc_q <= '0; skip_q <= '0;
    end else begin
      pos_q <= pos_d; br_q <= br_fin; hc_q <= hc_d; cl_q <= cl_d;
      body_q <= body_fin; halt_q <= halt_d; hasc_q <= hasc_d; skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 5; i++) hbuf_q[i] <= hbuf_d[i];
    if (stack_we) stack_q[stack_widx] <= stack_wdata;
  end

  // result burst
  ntlv_pkg::burst_t burst;
  always_comb begin
    burst = '0;
    if (emit_hdr) burst.count = CW'(1);
    else if (emit_six) burst.count = CW'(ntlv_pkg::HdrBytes);
    else if (emit_body) burst.count = CW'(1);
    else if (emit_close) burst.count = hc_mid;
    for (int i = 0; i < N; i++) begin
      if (emit_hdr && i == 0) begin
        burst.items[i].kind           = ntlv_pkg::KindHeader;
        burst.items[i].record_offset  = rstart_q + (pos_s - 32'd5);
        burst.items[i].tag_value      = tag;
        burst.items[i].body_size      = size;
        burst.items[i].nest_level     = 4'(cl_s);
        burst.items[i].is_container   = isc;
        burst.items[i].depth_overflow = ovf;
      end else if (emit_six && i < ntlv_pkg::HdrBytes) begin
        burst.items[i].kind         = ntlv_pkg::KindPayload;
        burst.items[i].payload_byte = sixb[i];
      end else if (emit_body && i == 0) begin
        burst.items[i].kind         = ntlv_pkg::KindPayload;
        burst.items[i].payload_byte = b;
      end else if (emit_close && i < 5 && i < 32'(hc_mid)) begin
        burst.items[i].kind         = ntlv_pkg::KindPayload;
        burst.items[i].payload_byte = hbuf_d[i];
      end
      burst.items[i].last_of_input = (burst.count != '0) && (i == 32'(burst.count) - 1);
    end
  end

  ntlv_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (in_accept),
    .load_i      (burst),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .in_stall_o  (in_stall_o)
  );

  `ASSERT_DEF(a_level_bound, 32'(cl_q) <= MAX_DEPTH)
  `ASSERT_DEF(a_body_has_bytes, body_q |-> br_q != '0)
  `ASSERT_DEF(a_halt_silent, halt_q && in_accept && !in_data_i.first_byte |=> !out_valid_o)

endmodule
`default_nettype wire

FILE: tb/sv/nested_tlv_record_parser_checker.sv
// Checker for the nested TLV parser: tracks transfers, predicts results, compares
`timescale 1ns / 1ps
module nested_tlv_record_parser_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ntlv_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ntlv_pkg::out_item_t out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import ntlv_pkg::*;

  localparam int Depth = 8;

  logic [31:0] region_base, region_len, pos;
  logic [31:0] level_end [Depth];
  logic        level_child [Depth];
  logic        level_skip [Depth];
  logic [7:0]  hdr_buf [HdrBytes];
  int          hdr_cnt, cur_level;
  logic [31:0] body_left;
  logic        in_body, halted;

  out_item_t step_results [$];
  out_item_t expected_results [$];

  function automatic logic tag_in_set(logic [15:0] tag);
    logic hit;
    hit = 1'b0;
    foreach (ContainerTags[i]) if (ContainerTags[i] == tag) hit = 1'b1;
    return hit;
  endfunction

  function automatic void emit(logic kind, logic [31:0] off, logic [15:0] tag,
                               logic [31:0] size, logic [3:0] lv, logic isc,
                               logic ovf, logic [7:0] b);
    out_item_t r;
    if (step_results.size() >= MaxResults) return;
    r = '0;
    r.kind = kind;
    r.record_offset = off;
    r.tag_value = tag;
    r.body_size = size;
    r.nest_level = lv;
    r.is_container = isc;
    r.depth_overflow = ovf;
    r.payload_byte = b;
    step_results = {step_results, r};
  endfunction

  function automatic void emit_payload(logic [7:0] b);
    emit(KindPayload, '0, '0, '0, '0, 1'b0, 1'b0, b);
  endfunction

  function automatic void clear_parser();
    pos = '0;
    for (int i = 0; i < Depth; i++) begin
      level_end[i] = '0;
      level_child[i] = 1'b0;
      level_skip[i] = 1'b0;
    end
    for (int i = 0; i < HdrBytes; i++) hdr_buf[i] = '0;
    hdr_cnt = 0;
    cur_level = 0;
    body_left = '0;
    in_body = 1'b0;
    halted = 1'b0;
  endfunction

  function automatic void close_header(logic [31:0] p);
    logic [31:0] size;
    logic [15:0] tag;
    longint unsigned lim, rem;
    logic isc, ovf;
    int lv;
    lv = cur_level;
    size = {hdr_buf[5], hdr_buf[4], hdr_buf[3], hdr_buf[2]};
    lim = (lv == 0) ? longint'(region_len) : longint'(level_end[lv-1]);
    rem = (lim > longint'(p) + 1) ? lim - longint'(p) - 1 : 0;
    hdr_cnt = 0;
    if (longint'(size) <= rem) begin
      tag = {hdr_buf[0], hdr_buf[1]};
      isc = (size != 0) && tag_in_set(tag);
      ovf = isc && (lv >= Depth);
      emit(KindHeader, region_base + (p - 32'd5), tag, size, 4'(lv), isc, ovf, '0);
      if (lv >= 1) level_child[lv-1] = 1'b1;
      if (isc && !ovf) begin
        level_end[lv] = p + 32'd1 + size;
        level_child[lv] = 1'b0;
        level_skip[lv] = 1'b0;
        cur_level = lv + 1;
      end else if (size != 0) begin
        in_body = 1'b1;
        body_left = size;
      end
    end else if (lv == 0) begin
      halted = 1'b1;
    end else if (!level_child[lv-1]) begin
      // first child is bad: the container body becomes payload
      for (int i = 0; i < HdrBytes; i++) emit_payload(hdr_buf[i]);
      cur_level = lv - 1;
      if (rem != 0) begin
        in_body = 1'b1;
        body_left = 32'(rem);
      end
    end else begin
      level_skip[lv-1] = 1'b1;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fb);
    logic [31:0] p;
    step_results.delete();
    if (fb) clear_parser();
    if (pos >= region_len || halted) return;
    p = pos;
    pos = p + 1;
    if (in_body) begin
      emit_payload(b);
      if (body_left != 0) body_left--;
      if (body_left == 0) in_body = 1'b0;
    end else if (!(cur_level >= 1 && level_skip[cur_level-1])) begin
      hdr_buf[hdr_cnt % HdrBytes] = b;
      hdr_cnt++;
      if (hdr_cnt >= HdrBytes) close_header(p);
    end
    // all levels ending on this byte close here, innermost first
    while (cur_level >= 1 && level_end[cur_level-1] <= pos) begin
      if (!level_child[cur_level-1] && !level_skip[cur_level-1])
        for (int i = 0; i < hdr_cnt && i < HdrBytes; i++) emit_payload(hdr_buf[i]);
      cur_level--;
      hdr_cnt = 0;
      in_body = 1'b0;
      body_left = '0;
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last_of_input = 1'b1;
    expected_results = {expected_results, step_results};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report("unexpected result", got.payload_byte, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.kind != want.kind) report("kind", got.kind, want.kind);
    if (got.record_offset != want.record_offset)
      report("record_offset", got.record_offset, want.record_offset);
    if (got.tag_value != want.tag_value) report("tag_value", got.tag_value, want.tag_value);
    if (got.body_size != want.body_size) report("body_size", got.body_size, want.body_size);
    if (got.nest_level != want.nest_level)
      report("nest_level", got.nest_level, want.nest_level);
    if (got.is_container != want.is_container)
      report("is_container", got.is_container, want.is_container);
    if (got.depth_overflow != want.depth_overflow)
      report("depth_overflow", got.depth_overflow, want.depth_overflow);
    if (got.payload_byte != want.payload_byte)
      report("payload_byte", got.payload_byte, want.payload_byte);
    if (got.last_of_input != want.last_of_input)
      report("last_of_input", got.last_of_input, want.last_of_input);
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    region_base = '0;
    region_len = '0;
    clear_parser();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base = '0;
      region_len = '0;
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == RegRegionLength) region_len = pwdata_i;
        else region_base = pwdata_i;
      end
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i.data_byte, in_data_i.first_byte);
    end
    pending_o = expected_results.size();
  end
endmodule

FILE: tb/sv/nested_tlv_record_parser_core_test.sv
// Top of the nested TLV parser testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module nested_tlv_record_parser_core_test;
  import ntlv_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int CycleLimit = 300000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_item_t    in_data;
  out_item_t   out_data;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, cycles;
  int          burst_left;
  logic        hold_req;

  nested_tlv_record_parser_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  nested_tlv_record_parser_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: stall pattern is redrawn at random from three modes; one long hold-off on request
  initial begin : receiver
    int mode, hold_cnt;
    mode = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (cycles % 50 == 0) mode = $urandom_range(0, 2);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic reg_write(logic idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_region(logic [31:0] base, logic [31:0] len);
    wait_idle();
    reg_write(RegRegionStart, base);
    reg_write(RegRegionLength, len);
  endtask

  task automatic send_byte(logic [7:0] b, logic fb);
    logic stalled;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, first_byte: fb};
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    burst_left--;
  endtask

  task automatic send_region(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == 0);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic byte_q_t header(logic [15:0] tag, logic [31:0] len);
    byte_q_t q;
    q = '{tag[15:8], tag[7:0], len[7:0], len[15:8], len[23:16], len[31:24]};
    return q;
  endfunction

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q = {q, 8'($urandom)};
    return q;
  endfunction

  // well-formed records with random content, sometimes a broken length
  function automatic byte_q_t gen_level(int depth, int budget);
    byte_q_t q, body;
    logic [15:0] tag;
    int room, len;
    while (budget - q.size() >= 6 && $urandom_range(0, 4) != 0) begin
      room = budget - q.size() - 6;
      len = $urandom_range(0, room < 14 ? room : 14);
      if (depth < 9 && len >= 6 && $urandom_range(0, 1)) begin
        tag = ContainerTags[$urandom_range(0, NumTags - 1)];
        body = gen_level(depth + 1, len);
        while (body.size() < len) body = {body, 8'($urandom)};
      end else begin
        tag = 16'($urandom);
        body = random_bytes(len);
      end
      if ($urandom_range(0, 11) == 0) begin
        q = {q, header(tag, $urandom_range(0, 1) ? 32'hFFFF_FFFF : len + room + 1)};
        q = {q, random_bytes($urandom_range(0, 8))};
        return q;
      end
      q = {q, header(tag, len), body};
    end
    q = {q, random_bytes($urandom_range(0, 5))};
    return q;
  endfunction

  initial begin : stimulus
    byte_q_t q, chain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    cycles = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_region(32'h0, 32'hFFFF_FFFF);
    // extreme leaf bytes, zero-length leaf, empty container tag
    send_region({header(16'hFFFF, 2), 8'hFF, 8'h00, header(16'h0000, 0),
                 header(16'hF401, 0)});
    // nesting one past the stack depth: innermost container is flagged
    chain = {header(16'h1234, 2), 8'hA5, 8'h5A};
    for (int i = 0; i < 9; i++) chain = {header(16'hF401, chain.size()), chain};
    send_region(chain);
    // bad top-level length halts until the next region
    send_region({header(16'h0101, 32'hFFFF_FFFF), 8'h11, 8'h22});
    // bad first child, short tail in an empty container, bad child after a good one
    send_region({header(16'hD430, 8), header(16'h0202, 9), 8'h33, 8'h44});
    send_region({header(16'h401F, 3), 8'h55, 8'h66, 8'h77});
    send_region({header(16'h7C15, 16), header(16'h0303, 0), header(16'h0404, 7),
                 8'h88, 8'h99, 8'hAA, 8'hBB});

    // offset at the top of the address range and bytes past the region end
    set_region(32'hFFFF_FFFC, 32'd14);
    send_region({header(16'h8813, 4), 8'h01, 8'h02, 8'h03, 8'h04, 8'hEE, 8'hEE});
    set_region(32'h0, 32'h0);
    send_region({header(16'h1111, 0)});

    for (int ph = 0; ph < 2; ph++) begin
      set_region($urandom, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(20, 60));
      if (ph == 1) hold_req = 1'b1;
      for (int r = 0; r < 2; r++) begin
        if ($urandom_range(0, 9) == 0) q = random_bytes($urandom_range(1, 12));
        else q = gen_level(0, $urandom_range(8, 20));
        send_region(q);
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
